[hw/rtl/tccw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    localparam int KIND_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int COL_IN_W   = 7;
    localparam int ROW_IN_W   = 5;
    localparam int ADDR_OUT_W = 11;
    localparam int CELL_W     = 16;
    localparam int COLOUR_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'h0A;
    localparam logic [COLOUR_W-1:0] BACK_RESET   = 4'd3;
    localparam logic [COLOUR_W-1:0] FORE_RESET   = 4'd15;

    localparam logic [KIND_W-1:0] KIND_PUT_CHAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RAW_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_CURSOR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PUT_AT     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd5;

    // Decoded operation, as carried through the command queue
    typedef enum logic [2:0] {
        OP_PUT        = 3'd0,
        OP_NEWLINE    = 3'd1,
        OP_PUT_AT     = 3'd2,
        OP_NEWLINE_AT = 3'd3,
        OP_SET_CURSOR = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_READ       = 3'd6,
        OP_NOP        = 3'd7
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CHAR_W-1:0]   char_code;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic [COLOUR_W-1:0] back;
        logic [COLOUR_W-1:0] fore;
    } t_colours;

    typedef struct packed {
        logic [COL_IN_W-1:0]   cursor_col;
        logic [ROW_IN_W-1:0]   cursor_row;
        logic                  cell_written;
        logic [ADDR_OUT_W-1:0] cell_address;
        logic [CELL_W-1:0]     cell_value;
        logic                  scrolled;
    } t_result;

    // Attribute byte high (background, foreground), character low
    function automatic logic [CELL_W-1:0] make_cell(input logic [COLOUR_W-1:0] back,
                                                    input logic [COLOUR_W-1:0] fore,
                                                    input logic [CHAR_W-1:0]   ch);
        make_cell = {back, fore, ch};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tccw_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_front import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic [COL_IN_W-1:0] i_col_in,
    input  wire logic [ROW_IN_W-1:0] i_row_in,
    output t_cmd                     o_cmd
);

    localparam logic [COL_IN_W:0]   COL_LIMIT = (COL_IN_W+1)'(COLUMNS);
    localparam logic [ROW_IN_W+1:0] ROW_LIMIT = (ROW_IN_W+2)'(ROWS);

    logic is_newline;

    assign is_newline = (i_char_code == NEWLINE_CODE);

    always_comb begin
        // positions clamp to the grid
        o_cmd.col = ({1'b0, i_col_in} >= COL_LIMIT) ? COL_IN_W'(COLUMNS - 1) : i_col_in;
        o_cmd.row = ({2'b00, i_row_in} >= ROW_LIMIT) ? ROW_IN_W'(ROWS - 1) : i_row_in;
        o_cmd.char_code = i_char_code;
        unique case (i_kind)
            KIND_PUT_CHAR:   o_cmd.op = is_newline ? OP_NEWLINE : OP_PUT;
            KIND_RAW_WRITE:  o_cmd.op = OP_PUT;
            KIND_SET_CURSOR: o_cmd.op = OP_SET_CURSOR;
            KIND_CLEAR:      o_cmd.op = OP_CLEAR;
            KIND_PUT_AT:     o_cmd.op = is_newline ? OP_NEWLINE_AT : OP_PUT_AT;
            KIND_READ:       o_cmd.op = OP_READ;
            default:         o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/tccw_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_queue import tccw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_head,
    output logic      o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tccw_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_back import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire t_cmd     i_q_head,
    input  wire t_colours i_colours,
    output logic          o_pop,
    output logic          o_init_busy,
    output logic          o_strobe,
    output t_result       o_result
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int AHEAD_W    = ADDR_W + 1;

    localparam logic [ADDR_W-1:0]  LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0]  LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0]  ROW_STRIDE    = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]   LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [AHEAD_W-1:0] AHEAD_STEP    = AHEAD_W'(COLUMNS + 1);
    localparam logic [AHEAD_W-1:0] AHEAD_LIMIT   = AHEAD_W'(CELL_COUNT);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_READ   = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_SCROLL = 6'b100000
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_strobe;

    logic              r_res_written;
    logic [ADDR_W-1:0] r_res_addr;
    logic [CELL_W-1:0] r_res_value;
    logic              r_res_scrolled;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    logic              is_pos;
    logic              is_write;
    logic              is_newline;
    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    logic [ADDR_W-1:0] tgt_addr;
    logic              at_last_col;
    logic              at_last_row;
    logic [ROW_W-1:0]  nl_row;
    logic              go_scroll;
    logic [CELL_W-1:0] new_value;
    logic [CELL_W-1:0] blank_value;
    logic [AHEAD_W-1:0] ahead;
    logic              ahead_ok;
    logic              sweep_done;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign is_pos     = (r_cmd.op == OP_PUT_AT) || (r_cmd.op == OP_NEWLINE_AT)
                     || (r_cmd.op == OP_READ) || (r_cmd.op == OP_SET_CURSOR);
    assign is_write   = (r_cmd.op == OP_PUT) || (r_cmd.op == OP_PUT_AT);
    assign is_newline = (r_cmd.op == OP_NEWLINE) || (r_cmd.op == OP_NEWLINE_AT);

    assign tgt_col  = is_pos ? COL_W'(r_cmd.col) : r_cur_col;
    assign tgt_row  = is_pos ? ROW_W'(r_cmd.row) : r_cur_row;
    assign tgt_addr = ADDR_W'(tgt_row) * ROW_STRIDE + ADDR_W'(tgt_col);

    assign at_last_col = (tgt_col == LAST_COL);
    assign at_last_row = (tgt_row == LAST_ROW);
    assign nl_row      = at_last_row ? tgt_row : tgt_row + ROW_W'(1);
    assign go_scroll   = (is_write && at_last_col && at_last_row) || (is_newline && at_last_row);

    assign new_value   = make_cell(i_colours.back, i_colours.fore, r_cmd.char_code);
    assign blank_value = make_cell(i_colours.back, i_colours.fore, '0);

    // scroll reads one row plus one cell ahead of the write pointer
    assign ahead      = {1'b0, r_ptr} + AHEAD_STEP;
    assign ahead_ok   = (ahead < AHEAD_LIMIT);
    assign sweep_done = (r_ptr == LAST_CELL);

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_init_busy = (r_state == S_INIT);
    assign o_strobe    = r_strobe;

    assign o_result.cursor_col   = COL_IN_W'(r_cur_col);
    assign o_result.cursor_row   = ROW_IN_W'(r_cur_row);
    assign o_result.cell_written = r_res_written;
    assign o_result.cell_address = ADDR_OUT_W'(r_res_addr);
    assign o_result.cell_value   = r_res_value;
    assign o_result.scrolled     = r_res_scrolled;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = blank_value;
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        unique case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = make_cell(BACK_RESET, FORE_RESET, '0);
            end
            S_EXEC: begin
                if (is_write) begin
                    wr_en   = 1'b1;
                    wr_addr = tgt_addr;
                    wr_data = new_value;
                end
                if (r_cmd.op == OP_READ) begin
                    rd_en   = 1'b1;
                    rd_addr = tgt_addr;
                end else if (go_scroll) begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_STRIDE;
                end
            end
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_SCROLL: begin
                wr_en   = 1'b1;
                wr_data = (r_ptr < LAST_ROW_BASE) ? r_rdata : blank_value;
                rd_en   = ahead_ok;
                rd_addr = ADDR_W'(ahead);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_cells[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= sweep_done ? '0 : r_ptr + 1'b1;
                    if (sweep_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.op)
                        OP_PUT: begin
                            r_cur_col <= at_last_col ? '0 : tgt_col + COL_W'(1);
                            r_cur_row <= at_last_col ? nl_row : tgt_row;
                        end
                        OP_NEWLINE: begin
                            r_cur_col <= '0;
                            r_cur_row <= nl_row;
                        end
                        OP_SET_CURSOR: begin
                            r_cur_col <= tgt_col;
                            r_cur_row <= tgt_row;
                        end
                        OP_CLEAR: begin
                            r_cur_col <= '0;
                            r_cur_row <= '0;
                        end
                        default: begin
                            r_cur_col <= r_cur_col;
                        end
                    endcase
                    if (r_cmd.op == OP_CLEAR) begin
                        r_state <= S_CLEAR;
                    end else if (r_cmd.op == OP_READ) begin
                        r_state <= S_READ;
                    end else if (go_scroll) begin
                        r_state <= S_SCROLL;
                    end else begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                S_CLEAR, S_SCROLL: begin
                    r_ptr <= sweep_done ? '0 : r_ptr + 1'b1;
                    if (sweep_done) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_head;
        end
        if (r_state == S_EXEC) begin
            r_res_written  <= is_write;
            r_res_addr     <= (is_write || (r_cmd.op == OP_READ)) ? tgt_addr : '0;
            r_res_value    <= is_write ? new_value : '0;
            r_res_scrolled <= go_scroll;
        end else if (r_state == S_READ) begin
            r_res_value <= r_rdata;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/text_console_cell_writer_unit.sv]
// Path: start pushes a command into the queue, the back-end sequencer pops and executes it,
// and a registered strobe gives the result; a cell read first passes a read state, and a
// clear or a scroll first sweeps the cell memory one cell a cycle. Commands run one at a time
// through the pop and execute steps of the back-end sequencer; a 2-deep command queue lets
// start be taken while it works. Reset: synchronous, active low; a clearing pass then blanks
// the cell memory in the reset colours with busy held high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer_unit import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // command transaction
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [COL_IN_W-1:0]   i_col_in,
    input  wire logic [ROW_IN_W-1:0]   i_row_in,

    // result transaction, one cycle wide
    output logic                       o_strobe,
    output logic [COL_IN_W-1:0]        o_cursor_col,
    output logic [ROW_IN_W-1:0]        o_cursor_row,
    output logic                       o_cell_written,
    output logic [ADDR_OUT_W-1:0]      o_cell_address,
    output logic [CELL_W-1:0]          o_cell_value,
    output logic                       o_scrolled,

    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // Colour registers: background at 0x0, foreground at 0x4.
    // Only paddr[2] is decoded.
    logic [COLOUR_W-1:0] r_back_colour;
    logic [COLOUR_W-1:0] r_fore_colour;
    logic                cfg_write;

    t_cmd     front_cmd;
    t_cmd     q_head;
    logic     q_valid;
    logic     q_full;
    logic     q_pop;
    logic     push;
    logic     init_busy;
    t_colours colours;
    t_result  result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {{(32 - COLOUR_W){1'b0}}, paddr[2] ? r_fore_colour : r_back_colour};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_colour <= BACK_RESET;
            r_fore_colour <= FORE_RESET;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                r_fore_colour <= pwdata[COLOUR_W-1:0];
            end else begin
                r_back_colour <= pwdata[COLOUR_W-1:0];
            end
        end
    end

    assign colours.back = r_back_colour;
    assign colours.fore = r_fore_colour;

    // No command is taken during the post-reset clearing pass or with the queue full.
    assign busy = q_full || init_busy;
    assign push = start && !busy;

    // Front end: decode the kind, spot newlines and clamp positions.
    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_col_in    (i_col_in),
        .i_row_in    (i_row_in),
        .o_cmd       (front_cmd)
    );

    // Decoupling queue between decode and execution.
    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    // Back end: cursor, cell memory, wrap, scroll and clear sweeps.
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .i_colours   (colours),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_strobe    (o_strobe),
        .o_result    (result)
    );

    assign o_cursor_col   = result.cursor_col;
    assign o_cursor_row   = result.cursor_row;
    assign o_cell_written = result.cell_written;
    assign o_cell_address = result.cell_address;
    assign o_cell_value   = result.cell_value;
    assign o_scrolled     = result.scrolled;

endmodule

`default_nettype wire
